// ----- rtl/lpbp_pkg.sv -----
package lpbp_pkg;

    // lamp mode, one-hot
    typedef enum logic [3:0] {
        MODE_OFF     = 4'b0001,
        MODE_ON      = 4'b0010,
        MODE_LOW     = 4'b0100,
        MODE_PATTERN = 4'b1000
    } t_mode;

    // encoded mode as seen on the result port
    localparam logic [1:0] MODE_CODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_CODE_ON      = 2'd1;
    localparam logic [1:0] MODE_CODE_LOW     = 2'd2;
    localparam logic [1:0] MODE_CODE_PATTERN = 2'd3;

    // register map, index into paddr[3:2]
    localparam logic [1:0] REG_EMPTY_MV     = 2'd0;
    localparam logic [1:0] REG_FULL_MV      = 2'd1;
    localparam logic [1:0] REG_BLINK_ON     = 2'd2;
    localparam logic [1:0] REG_BLINK_PERIOD = 2'd3;

    localparam int ADDR_W   = 4;
    localparam int MV_W     = 13;
    localparam int TICK_W   = 8;
    localparam int IDX_W    = 4;
    localparam int LED_W    = 16;
    localparam int LEVEL_W  = 8;
    localparam int RAW_W    = 8;
    localparam int BTN_W    = 2;
    localparam int CODE_W   = 2;

    localparam logic [MV_W-1:0]   RST_EMPTY_MV     = 13'd3300;
    localparam logic [MV_W-1:0]   RST_FULL_MV      = 13'd3700;
    localparam logic [TICK_W-1:0] RST_BLINK_ON     = 8'd15;
    localparam logic [TICK_W-1:0] RST_BLINK_PERIOD = 8'd20;

    localparam logic [LEVEL_W-1:0] LEVEL_ON  = 8'd250;
    localparam logic [TICK_W-1:0]  TIMER_TOP = 8'd255;

    // floor(raw*5000/255) == (raw*MV_RECIP) >> MV_SHIFT for every 8-bit raw
    localparam int          MV_SHIFT = 16;
    localparam logic [20:0] MV_RECIP = 21'd1285020;
    localparam int          MV_PROD_W = RAW_W + 21;

    localparam logic [LED_W-1:0] LED_TABLE [16] = '{
        16'hFFFF, 16'h8001, 16'hE007, 16'h1E78, 16'h0180, 16'hAAAA, 16'h5555, 16'hCCCC,
        16'h3333, 16'hF0F0, 16'hFF00, 16'hB38F, 16'hF1CD, 16'h4002, 16'h2004, 16'h1FF8
    };

    typedef struct packed {
        logic [MV_W-1:0]   empty_mv;
        logic [MV_W-1:0]   full_mv;
        logic [TICK_W-1:0] blink_on;
        logic [TICK_W-1:0] blink_period;
    } t_cfg;

    typedef struct packed {
        logic [LED_W-1:0]   led_bits;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [CODE_W-1:0]  mode_now;
    } t_result;

    function automatic logic [CODE_W-1:0] mode_code(input t_mode m);
        logic [CODE_W-1:0] c;
        case (m)
            MODE_OFF:     c = MODE_CODE_OFF;
            MODE_ON:      c = MODE_CODE_ON;
            MODE_LOW:     c = MODE_CODE_LOW;
            MODE_PATTERN: c = MODE_CODE_PATTERN;
            default:      c = MODE_CODE_OFF;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/lpbp_cfg.sv -----
module lpbp_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lpbp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output lpbp_pkg::t_cfg               o_cfg
);

    lpbp_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.empty_mv     <= lpbp_pkg::RST_EMPTY_MV;
            r_cfg.full_mv      <= lpbp_pkg::RST_FULL_MV;
            r_cfg.blink_on     <= lpbp_pkg::RST_BLINK_ON;
            r_cfg.blink_period <= lpbp_pkg::RST_BLINK_PERIOD;
        end else if (wr_en) begin
            case (reg_idx)
                lpbp_pkg::REG_EMPTY_MV:     r_cfg.empty_mv     <= pwdata[lpbp_pkg::MV_W-1:0];
                lpbp_pkg::REG_FULL_MV:      r_cfg.full_mv      <= pwdata[lpbp_pkg::MV_W-1:0];
                lpbp_pkg::REG_BLINK_ON:     r_cfg.blink_on     <= pwdata[lpbp_pkg::TICK_W-1:0];
                lpbp_pkg::REG_BLINK_PERIOD: r_cfg.blink_period <= pwdata[lpbp_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lpbp_pkg::REG_EMPTY_MV:     prdata = {19'd0, r_cfg.empty_mv};
            lpbp_pkg::REG_FULL_MV:      prdata = {19'd0, r_cfg.full_mv};
            lpbp_pkg::REG_BLINK_ON:     prdata = {24'd0, r_cfg.blink_on};
            lpbp_pkg::REG_BLINK_PERIOD: prdata = {24'd0, r_cfg.blink_period};
            default:                    prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/lpbp_step.sv -----
module lpbp_step #(
    parameter int PATTERN_COUNT = 16,
    parameter int LED_COUNT     = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lpbp_pkg::t_cfg               i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lpbp_pkg::BTN_W-1:0]   i_buttons,
    input  logic [lpbp_pkg::RAW_W-1:0]   i_battery_raw,
    input  logic                         i_res_take,
    output logic                         o_res_valid,
    output lpbp_pkg::t_result            o_res
);

    localparam logic [lpbp_pkg::LED_W-1:0] LED_MASK =
        lpbp_pkg::LED_W'((17'd1 << LED_COUNT) - 17'd1);
    localparam logic [lpbp_pkg::IDX_W:0] IDX_WRAP = (lpbp_pkg::IDX_W + 1)'(PATTERN_COUNT);

    // input register
    logic                         r_s1_valid;
    logic [lpbp_pkg::BTN_W-1:0]   r_btn;
    logic [lpbp_pkg::RAW_W-1:0]   r_raw;

    // tick state
    logic [lpbp_pkg::BTN_W-1:0]   r_prev,  n_prev;
    lpbp_pkg::t_mode              r_mode,  n_mode;
    logic [lpbp_pkg::IDX_W-1:0]   r_idx,   n_idx;
    logic                         r_en,    n_en;
    logic [lpbp_pkg::TICK_W-1:0]  r_timer, n_timer;
    logic [lpbp_pkg::LEVEL_W-1:0] r_red,   n_red;
    logic [lpbp_pkg::LEVEL_W-1:0] r_green, n_green;
    logic [lpbp_pkg::LED_W-1:0]   r_led,   n_led;

    logic                         fire;
    logic                         accept;
    logic [lpbp_pkg::MV_PROD_W-1:0] mv_prod;
    logic [lpbp_pkg::MV_W-1:0]    mv;
    logic [lpbp_pkg::BTN_W-1:0]   rise;
    logic                         power;
    logic                         pat;
    logic                         is_low;

    assign fire       = r_s1_valid & i_res_take;
    assign o_in_ready = ~r_s1_valid | i_res_take;
    assign accept     = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_btn <= i_buttons;
            r_raw <= i_battery_raw;
        end
    end

    // millivolt scaling by reciprocal multiply
    assign mv_prod = lpbp_pkg::MV_PROD_W'(r_raw) * lpbp_pkg::MV_PROD_W'(lpbp_pkg::MV_RECIP);
    assign mv      = mv_prod[lpbp_pkg::MV_SHIFT +: lpbp_pkg::MV_W];

    assign rise   = r_btn & ~r_prev;
    assign power  = rise[0];
    assign pat    = rise[1];
    assign is_low = mv < i_cfg.empty_mv;

    always_comb begin
        logic [lpbp_pkg::IDX_W:0]    v_ni;
        logic [lpbp_pkg::TICK_W-1:0] v_timer;
        n_prev  = r_prev;
        n_mode  = r_mode;
        n_idx   = r_idx;
        n_en    = r_en;
        n_red   = r_red;
        n_green = r_green;
        n_led   = r_led;
        v_ni    = {1'b0, r_idx} + 1'b1;
        v_timer = r_timer;
        n_prev  = r_btn;

        // later rules override earlier ones: power press wins
        case (r_mode)
            lpbp_pkg::MODE_OFF: begin
                n_led   = '0;
                n_en    = 1'b0;
                n_red   = '0;
                n_green = '0;
                if (power) n_mode = lpbp_pkg::MODE_ON;
            end
            lpbp_pkg::MODE_ON: begin
                n_red   = '0;
                n_green = lpbp_pkg::LEVEL_ON;
                if (pat)    n_mode = lpbp_pkg::MODE_PATTERN;
                if (is_low) n_mode = lpbp_pkg::MODE_LOW;
                if (power)  n_mode = lpbp_pkg::MODE_OFF;
            end
            lpbp_pkg::MODE_LOW: begin
                n_en  = 1'b1;
                n_led = '0;
                if (mv > i_cfg.full_mv) n_mode = lpbp_pkg::MODE_OFF;
                if (power)              n_mode = lpbp_pkg::MODE_OFF;
            end
            lpbp_pkg::MODE_PATTERN: begin
                if (is_low) n_mode = lpbp_pkg::MODE_LOW;
                if (power)  n_mode = lpbp_pkg::MODE_OFF;
                n_led = lpbp_pkg::LED_TABLE[r_idx];
                if (pat) begin
                    n_idx = (v_ni >= IDX_WRAP) ? '0 : v_ni[lpbp_pkg::IDX_W-1:0];
                end
            end
            default: n_mode = lpbp_pkg::MODE_OFF;
        endcase

        // blink timer
        if (n_en) begin
            if (v_timer >= i_cfg.blink_on) begin
                n_red   = '0;
                n_green = '0;
            end
            if (v_timer >= i_cfg.blink_period) begin
                n_red   = lpbp_pkg::LEVEL_ON;
                n_green = '0;
                v_timer = '0;
            end
        end else begin
            v_timer = i_cfg.blink_period;
        end
        if (v_timer != lpbp_pkg::TIMER_TOP) v_timer = v_timer + 1'b1;
        n_timer = v_timer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_mode  <= lpbp_pkg::MODE_OFF;
            r_idx   <= '0;
            r_en    <= 1'b0;
            r_timer <= '0;
            r_red   <= '0;
            r_green <= '0;
            r_led   <= '0;
        end else if (fire) begin
            r_prev  <= n_prev;
            r_mode  <= n_mode;
            r_idx   <= n_idx;
            r_en    <= n_en;
            r_timer <= n_timer;
            r_red   <= n_red;
            r_green <= n_green;
            r_led   <= n_led;
        end
    end

    assign o_res_valid       = r_s1_valid;
    assign o_res.led_bits    = n_led & LED_MASK;
    assign o_res.red_level   = n_red;
    assign o_res.green_level = n_green;
    assign o_res.mode_now    = lpbp_pkg::mode_code(n_mode);

endmodule

// ----- rtl/lpbp_outq.sv -----
module lpbp_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  lpbp_pkg::t_result i_push,
    output logic              o_valid,
    input  logic              i_ready,
    output lpbp_pkg::t_result o_head
);

    lpbp_pkg::t_result r_q0;
    lpbp_pkg::t_result r_q1;
    logic [1:0]        r_cnt, n_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign push         = i_push_valid & o_push_ready;
    assign o_valid      = (r_cnt != 2'd0);
    assign pop          = o_valid & i_ready;
    assign o_head       = r_q0;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) n_cnt = r_cnt + 1'b1;
        if (pop && !push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop))) begin
            r_q0 <= i_push;
        end else if (pop && r_cnt == 2'd2) begin
            r_q0 <= r_q1;
        end
        if (push && r_cnt == 2'd1 && !pop) begin
            r_q1 <= i_push;
        end
    end

endmodule

// ----- rtl/lamp_power_battery_pattern_fsm_core.sv -----
// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+-------------------------------------
// tick in   | in        | i_in_valid / o_in_ready      | i_buttons, i_battery_raw
// result    | out       | o_out_valid / i_out_ready    | o_led_bits, o_red_level,
//           |           |                              | o_green_level, o_mode_now
// config    | in        | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// one item per cycle while the result side keeps taking items; an item's result passes
// the input register, then the tick update with its result pushed into a two-entry queue
// the reading-to-millivolt multiply and the threshold compares set the single-cycle path
// the two-entry result queue keeps the input side taking items while a result waits
// reset (synchronous, active low) returns the registers to their defaults and the
// lamp to off; there is no clearing pass
module lamp_power_battery_pattern_fsm_core #(
    parameter int PATTERN_COUNT = 16,
    parameter int LED_COUNT     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpbp_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // tick items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lpbp_pkg::BTN_W-1:0]    i_buttons,
    input  logic [lpbp_pkg::RAW_W-1:0]    i_battery_raw,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lpbp_pkg::LED_W-1:0]    o_led_bits,
    output logic [lpbp_pkg::LEVEL_W-1:0]  o_red_level,
    output logic [lpbp_pkg::LEVEL_W-1:0]  o_green_level,
    output logic [lpbp_pkg::CODE_W-1:0]   o_mode_now
);

    lpbp_pkg::t_cfg    cfg;
    lpbp_pkg::t_result step_res;
    lpbp_pkg::t_result head;
    logic              step_valid;
    logic              q_ready;

    // threshold and blink registers
    lpbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register plus per-tick mode, index and blink update
    lpbp_step #(
        .PATTERN_COUNT (PATTERN_COUNT),
        .LED_COUNT     (LED_COUNT)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_buttons     (i_buttons),
        .i_battery_raw (i_battery_raw),
        .i_res_take    (q_ready),
        .o_res_valid   (step_valid),
        .o_res         (step_res)
    );

    // result queue, decouples downstream stalls from tick acceptance
    lpbp_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (step_valid),
        .o_push_ready (q_ready),
        .i_push       (step_res),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_head       (head)
    );

    assign o_led_bits    = head.led_bits;
    assign o_red_level   = head.red_level;
    assign o_green_level = head.green_level;
    assign o_mode_now    = head.mode_now;

endmodule

// ----- test/tb_lamp_power_battery_pattern_fsm_core.sv -----
`timescale 1ns / 1ps

module tb_lamp_power_battery_pattern_fsm_core;

    // build of the block under test
    localparam int PATTERN_COUNT = 16;
    localparam int LED_COUNT     = 16;
    localparam logic [lpbp_pkg::LED_W-1:0] LED_MASK =
        lpbp_pkg::LED_W'((32'd1 << LED_COUNT) - 1);

    // result shows after the input register and the result queue, allow a little slack
    localparam int LATENCY      = 2;
    localparam int RANDOM_TICKS = 110;
    localparam int PHASES       = 7;
    localparam int DIR_ROWS     = 25;

    // one directed tick, with an optional hand-written result
    typedef struct packed {
        logic [lpbp_pkg::BTN_W-1:0] btn;
        logic [lpbp_pkg::RAW_W-1:0] raw;
        logic                       typed;
        lpbp_pkg::t_result          res;
    } t_tick_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [lpbp_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [lpbp_pkg::BTN_W-1:0]   i_buttons = '0;
    logic [lpbp_pkg::RAW_W-1:0]   i_battery_raw = '0;

    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [lpbp_pkg::LED_W-1:0]   o_led_bits;
    logic [lpbp_pkg::LEVEL_W-1:0] o_red_level;
    logic [lpbp_pkg::LEVEL_W-1:0] o_green_level;
    logic [lpbp_pkg::CODE_W-1:0]  o_mode_now;

    lamp_power_battery_pattern_fsm_core #(
        .PATTERN_COUNT (PATTERN_COUNT),
        .LED_COUNT     (LED_COUNT)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_buttons     (i_buttons),
        .i_battery_raw (i_battery_raw),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_led_bits    (o_led_bits),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_mode_now    (o_mode_now)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // shadow copy of the lamp controller
    // ---------------------------------------------------------------------
    lpbp_pkg::t_cfg               lamp_cfg;
    logic [lpbp_pkg::BTN_W-1:0]   lamp_prev_btn;
    logic [lpbp_pkg::CODE_W-1:0]  lamp_mode;
    logic [lpbp_pkg::IDX_W-1:0]   lamp_idx;
    logic                         lamp_blink_en;
    logic [lpbp_pkg::TICK_W-1:0]  lamp_timer;
    logic [lpbp_pkg::LEVEL_W-1:0] lamp_red;
    logic [lpbp_pkg::LEVEL_W-1:0] lamp_green;
    logic [lpbp_pkg::LED_W-1:0]   lamp_led;

    lpbp_pkg::t_result lamp_outputs_due [$];
    int                fault_count = 0;
    bit                no_idle = 1'b0;    // phase with both sides running flat out

    // random stimulus keeps button levels and a slowly moving battery level
    logic [lpbp_pkg::BTN_W-1:0] held_btn = '0;
    logic [lpbp_pkg::RAW_W-1:0] batt_level = 8'd200;

    function automatic void reset_lamp_shadow();
        lamp_cfg      = '{lpbp_pkg::RST_EMPTY_MV, lpbp_pkg::RST_FULL_MV,
                          lpbp_pkg::RST_BLINK_ON, lpbp_pkg::RST_BLINK_PERIOD};
        lamp_prev_btn = '0;
        lamp_mode     = lpbp_pkg::MODE_CODE_OFF;
        lamp_idx      = '0;
        lamp_blink_en = 1'b0;
        lamp_timer    = '0;
        lamp_red      = '0;
        lamp_green    = '0;
        lamp_led      = '0;
    endfunction

    // one 10 ms tick: mode rules on the old mode, then the blink timer
    function automatic lpbp_pkg::t_result advance_lamp(
        input logic [lpbp_pkg::BTN_W-1:0] btn,
        input logic [lpbp_pkg::RAW_W-1:0] raw);
        logic [lpbp_pkg::BTN_W-1:0]  rise;
        logic [lpbp_pkg::CODE_W-1:0] next_mode;
        int                          mv;
        int                          next_idx;
        lpbp_pkg::t_result           r;
        rise      = (lamp_prev_btn ^ btn) & btn;
        mv        = int'(raw) * 5000 / 255;
        next_mode = lamp_mode;
        lamp_prev_btn = btn;
        // later rules win, so the power press is always checked last
        case (lamp_mode)
            lpbp_pkg::MODE_CODE_OFF: begin
                lamp_led      = '0;
                lamp_blink_en = 1'b0;
                lamp_red      = '0;
                lamp_green    = '0;
                if (rise[0]) next_mode = lpbp_pkg::MODE_CODE_ON;
            end
            lpbp_pkg::MODE_CODE_ON: begin
                lamp_red   = '0;
                lamp_green = lpbp_pkg::LEVEL_ON;
                if (rise[1]) next_mode = lpbp_pkg::MODE_CODE_PATTERN;
                if (mv < int'(lamp_cfg.empty_mv)) next_mode = lpbp_pkg::MODE_CODE_LOW;
                if (rise[0]) next_mode = lpbp_pkg::MODE_CODE_OFF;
            end
            lpbp_pkg::MODE_CODE_LOW: begin
                lamp_blink_en = 1'b1;
                lamp_led      = '0;
                if (mv > int'(lamp_cfg.full_mv)) next_mode = lpbp_pkg::MODE_CODE_OFF;
                if (rise[0]) next_mode = lpbp_pkg::MODE_CODE_OFF;
            end
            default: begin
                if (mv < int'(lamp_cfg.empty_mv)) next_mode = lpbp_pkg::MODE_CODE_LOW;
                if (rise[0]) next_mode = lpbp_pkg::MODE_CODE_OFF;
                // LEDs show the entry before the press moves the index
                lamp_led = lpbp_pkg::LED_TABLE[lamp_idx];
                if (rise[1]) begin
                    next_idx = int'(lamp_idx) + 1;
                    if (next_idx >= PATTERN_COUNT) next_idx = 0;
                    lamp_idx = lpbp_pkg::IDX_W'(next_idx);
                end
            end
        endcase
        lamp_mode = next_mode;

        if (lamp_blink_en) begin
            if (lamp_timer >= lamp_cfg.blink_on) begin
                lamp_red   = '0;
                lamp_green = '0;
            end
            if (lamp_timer >= lamp_cfg.blink_period) begin
                lamp_red   = lpbp_pkg::LEVEL_ON;
                lamp_green = '0;
                lamp_timer = '0;
            end
        end else begin
            lamp_timer = lamp_cfg.blink_period;
        end
        // timer sticks at its top
        if (lamp_timer != lpbp_pkg::TIMER_TOP) lamp_timer = lamp_timer + 1'b1;

        r.led_bits    = lamp_led & LED_MASK;
        r.red_level   = lamp_red;
        r.green_level = lamp_green;
        r.mode_now    = lamp_mode;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // directed ticks, from reset with the default thresholds
    // ---------------------------------------------------------------------
    t_tick_row stim_rows [DIR_ROWS] = '{
        // idle off, then power press turns the lamp on
        '{2'b00, 8'd0,   1'b1,
          '{16'h0000, 8'd0, 8'd0, lpbp_pkg::MODE_CODE_OFF}},
        '{2'b01, 8'd255, 1'b1,
          '{16'h0000, 8'd0, 8'd0, lpbp_pkg::MODE_CODE_ON}},
        '{2'b00, 8'd255, 1'b1,
          '{16'h0000, 8'd0, lpbp_pkg::LEVEL_ON, lpbp_pkg::MODE_CODE_ON}},
        // pattern press goes to pattern, then first entries of the table
        '{2'b10, 8'd255, 1'b1,
          '{16'h0000, 8'd0, lpbp_pkg::LEVEL_ON, lpbp_pkg::MODE_CODE_PATTERN}},
        '{2'b00, 8'd255, 1'b1,
          '{16'hFFFF, 8'd0, lpbp_pkg::LEVEL_ON, lpbp_pkg::MODE_CODE_PATTERN}},
        '{2'b10, 8'd255, 1'b1,
          '{16'hFFFF, 8'd0, lpbp_pkg::LEVEL_ON, lpbp_pkg::MODE_CODE_PATTERN}},
        '{2'b00, 8'd255, 1'b1,
          '{16'h8001, 8'd0, lpbp_pkg::LEVEL_ON, lpbp_pkg::MODE_CODE_PATTERN}},
        // both buttons at once: power wins, index still advances
        '{2'b11, 8'd255, 1'b1,
          '{16'h8001, 8'd0, lpbp_pkg::LEVEL_ON, lpbp_pkg::MODE_CODE_OFF}},
        '{2'b00, 8'd200, 1'b0, '0},
        '{2'b01, 8'd200, 1'b0, '0},
        // held button is not a press
        '{2'b01, 8'd200, 1'b0, '0},
        // just above, then just below the empty threshold
        '{2'b00, 8'd169, 1'b0, '0},
        '{2'b00, 8'd168, 1'b0, '0},
        // blink runs while the reading stays just under the full threshold
        '{2'b00, 8'd188, 1'b0, '0},
        '{2'b00, 8'd188, 1'b0, '0},
        '{2'b00, 8'd188, 1'b0, '0},
        '{2'b00, 8'd188, 1'b0, '0},
        '{2'b00, 8'd189, 1'b0, '0},
        '{2'b01, 8'd255, 1'b0, '0},
        '{2'b10, 8'd255, 1'b0, '0},
        // empty battery drops pattern to low, power press leaves low
        '{2'b00, 8'd0,   1'b0, '0},
        '{2'b01, 8'd0,   1'b0, '0},
        '{2'b00, 8'd255, 1'b0, '0},
        '{2'b11, 8'd255, 1'b0, '0},
        '{2'b01, 8'd255, 1'b0, '0}
    };

    // ---------------------------------------------------------------------
    // tick sender
    // ---------------------------------------------------------------------
    task automatic send_tick(input logic [lpbp_pkg::BTN_W-1:0] btn,
                             input logic [lpbp_pkg::RAW_W-1:0] raw,
                             input logic typed, input lpbp_pkg::t_result typed_res);
        int                gap;
        lpbp_pkg::t_result want;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_buttons     <= btn;
        i_battery_raw <= raw;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // item taken at this edge, the shadow moves on in step
        want = advance_lamp(btn, raw);
        if (typed) want = typed_res;
        lamp_outputs_due.push_back(want);
    endtask

    // stop sending and let every pending result drain
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (lamp_outputs_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic random_ticks(input int count);
        logic [lpbp_pkg::RAW_W-1:0] raw;
        for (int n = 0; n < count; n++) begin
            // power toggles rarely so modes last long enough for the blink
            if ($urandom_range(0, 9) == 0) held_btn[0] = ~held_btn[0];
            if ($urandom_range(0, 3) == 0) held_btn[1] = ~held_btn[1];
            if ($urandom_range(0, 11) == 0)
                batt_level = lpbp_pkg::RAW_W'($urandom_range(0, 255));
            // occasional noisy reading
            raw = ($urandom_range(0, 19) == 0) ? lpbp_pkg::RAW_W'($urandom_range(0, 255))
                                               : batt_level;
            send_tick(held_btn, raw, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------------
    // register port, only used while the block is idle
    // ---------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            lpbp_pkg::REG_EMPTY_MV:
                lamp_cfg.empty_mv     = val[lpbp_pkg::MV_W-1:0];
            lpbp_pkg::REG_FULL_MV:
                lamp_cfg.full_mv      = val[lpbp_pkg::MV_W-1:0];
            lpbp_pkg::REG_BLINK_ON:
                lamp_cfg.blink_on     = val[lpbp_pkg::TICK_W-1:0];
            lpbp_pkg::REG_BLINK_PERIOD:
                lamp_cfg.blink_period = val[lpbp_pkg::TICK_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_lamp_regs(input int empty_mv, input int full_mv,
                                     input int blink_on, input int blink_period);
        write_reg(lpbp_pkg::REG_EMPTY_MV, empty_mv);
        write_reg(lpbp_pkg::REG_FULL_MV, full_mv);
        write_reg(lpbp_pkg::REG_BLINK_ON, blink_on);
        write_reg(lpbp_pkg::REG_BLINK_PERIOD, blink_period);
    endtask

    // ---------------------------------------------------------------------
    // result receiver: random stall before each item
    // ---------------------------------------------------------------------
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------------
    // result checker, oldest expectation first
    // ---------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            fault_count++;
        end
    endfunction

    lpbp_pkg::t_result head_res;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lamp_outputs_due.size() == 0) begin
                $error("result item with no tick pending");
                fault_count++;
            end else begin
                head_res = lamp_outputs_due.pop_front();
                check_field("led_bits", 32'(head_res.led_bits), 32'(o_led_bits));
                check_field("red_level", 32'(head_res.red_level), 32'(o_red_level));
                check_field("green_level", 32'(head_res.green_level),
                            32'(o_green_level));
                check_field("mode_now", 32'(head_res.mode_now), 32'(o_mode_now));
            end
        end
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin
        reset_lamp_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part runs on the reset thresholds
        for (int k = 0; k < DIR_ROWS; k++)
            send_tick(stim_rows[k].btn, stim_rows[k].raw, stim_rows[k].typed,
                      stim_rows[k].res);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            no_idle = (ph == 5);
            case (ph)
                0: program_lamp_regs(3300, 3700, 15, 20);
                // zero thresholds, shortest blink
                1: program_lamp_regs(0, 0, 1, 1);
                // top of range, long blink reaching the timer top
                2: program_lamp_regs(5000, 5000, 255, 255);
                // thresholds past full scale, zero blink registers
                3: program_lamp_regs(8191, 8191, 0, 0);
                // on time longer than the period
                4: program_lamp_regs(4000, 2000, 200, 10);
                5: program_lamp_regs(3000, 4200, 3, 7);
                default: program_lamp_regs($urandom_range(2500, 4500),
                                           $urandom_range(2500, 4500),
                                           $urandom_range(1, 60), $urandom_range(1, 60));
            endcase
            if (ph == 4) begin
                // sender holds off until everything is back, then resumes
                random_ticks(RANDOM_TICKS / 2);
                drain_results();
                random_ticks(RANDOM_TICKS - RANDOM_TICKS / 2);
            end else begin
                random_ticks(RANDOM_TICKS);
            end
            drain_results();
        end
        no_idle = 1'b0;

        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
